// ----- design/ebd_pkg.sv -----
// Shared types and constants of the energy beat detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ebd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS    = SAMPLE_BITS + 1;
   localparam int ACC_BITS    = 25;
   localparam int CNT_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ACC_BITS-1:0] MIN_ENERGY_RESET = ACC_BITS'(2359296);
   localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_ENERGY = CSR_ADDR_BITS'(0);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ACC_BITS-1:0]           acc_type;

   typedef struct packed {
      logic    valid;
      acc_type left_sum;
      acc_type right_sum;
   } frame_type;

endpackage

// ----- design/energy_beat_detector_core.sv -----
// Top level of the energy beat detector: two channel lanes, merge stage, CSR.
// Depends on ebd_pkg, ebd_lane and ebd_peak.
//
//   channel  direction  transaction
//   req_     in         one stereo sample pair with frame end mark
//   rsp_     out        beat flag and frame energy, one per frame end
//   csr_     in/out     APB access to min_energy at byte address 0
//
// One sample pair is taken every cycle while req_ready is high; a frame end result
// reaches rsp_ through the lane registers, which hold the frame sums, and then the
// merge stage, which registers the result.
// Reset is synchronous and clears running sums, peaks and min_energy to its default, not the frame sums.
// A stalled result holds the merge stage; req_ready drops only while both the
// stage and the result register are full and rsp_ready is low.
`timescale 1ns / 1ps

module energy_beat_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ebd_pkg::sample_type                req_left_sample,
   input  ebd_pkg::sample_type                req_right_sample,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_is_beat,
   output ebd_pkg::acc_type                   rsp_frame_energy,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ebd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ebd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ebd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import ebd_pkg::*;

   logic      take;
   logic      out_free;
   logic      stage_valid_ff, stage_valid_in;
   frame_type frame;
   acc_type   left_frame_sum, right_frame_sum;
   acc_type   min_energy_ff, min_energy_in;
   logic      csr_hit;

   assign req_ready = !stage_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff && !out_free;
      if (take && req_frame_end) begin
         stage_valid_in = 1'b1;
      end
   end

   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_MIN_ENERGY[CSR_ADDR_BITS-1:2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(min_energy_ff) : '0;

   always_comb begin
      min_energy_in = min_energy_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         min_energy_in = csr_pwdata[ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         min_energy_ff  <= MIN_ENERGY_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         min_energy_ff  <= min_energy_in;
      end
   end

   ebd_lane u_left_lane (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .last      (req_frame_end),
      .sample    (req_left_sample),
      .frame_sum (left_frame_sum)
   );

   ebd_lane u_right_lane (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .last      (req_frame_end),
      .sample    (req_right_sample),
      .frame_sum (right_frame_sum)
   );

   assign frame.valid     = stage_valid_ff;
   assign frame.left_sum  = left_frame_sum;
   assign frame.right_sum = right_frame_sum;

   ebd_peak u_peak (
      .clock            (clock),
      .reset            (reset),
      .frame            (frame),
      .min_energy       (min_energy_ff),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_beat      (rsp_is_beat),
      .rsp_frame_energy (rsp_frame_energy)
   );

endmodule

// ----- design/ebd_lane.sv -----
// One channel lane: sample magnitude and saturating frame accumulator.
// Depends on ebd_pkg.
`timescale 1ns / 1ps

module ebd_lane (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               last,
   input  ebd_pkg::sample_type sample,
   output ebd_pkg::acc_type   frame_sum
);
   import ebd_pkg::*;

   logic signed [MAG_BITS-1:0] sample_ext;
   logic [MAG_BITS-1:0]        magnitude;
   logic [ACC_BITS:0]          sum_wide;
   acc_type                    sum_sat;
   acc_type                    acc_ff, acc_in;
   acc_type                    frame_sum_ff, frame_sum_in;

   assign sample_ext = MAG_BITS'(sample);
   assign magnitude  = sample[SAMPLE_BITS-1] ? MAG_BITS'(-sample_ext) : MAG_BITS'(sample_ext);
   assign sum_wide   = {1'b0, acc_ff} + (ACC_BITS+1)'(magnitude);
   assign sum_sat    = sum_wide[ACC_BITS] ? ACC_MAX : sum_wide[ACC_BITS-1:0];

   always_comb begin
      acc_in       = acc_ff;
      frame_sum_in = frame_sum_ff;
      if (take) begin
         if (last) begin
            acc_in       = '0;
            frame_sum_in = sum_sat;
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      frame_sum_ff <= frame_sum_in;
   end

   assign frame_sum = frame_sum_ff;

endmodule

// ----- design/ebd_peak.sv -----
// Merge stage: larger lane energy, peak tracking, beat decision, result register.
// Depends on ebd_pkg.
`timescale 1ns / 1ps

module ebd_peak (
   input  logic               clock,
   input  logic               reset,
   input  ebd_pkg::frame_type frame,
   input  ebd_pkg::acc_type   min_energy,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_beat,
   output ebd_pkg::acc_type   rsp_frame_energy
);
   import ebd_pkg::*;

   logic                take;
   acc_type             energy;
   logic [32:0]         mix;
   acc_type             slow_mix;
   logic [30:0]         thr_prod;
   logic [ACC_BITS:0]   threshold;
   logic                beat;
   logic [ACC_BITS:0]   pair_sum;
   logic [28:0]         decay_prod;

   acc_type             slow_ff, slow_in;
   acc_type             decay_ff, decay_in;
   acc_type             last_beat_ff, last_beat_in;
   logic [CNT_BITS-1:0] since_ff, since_in;
   logic                valid_ff, valid_in;
   logic                beat_ff, beat_in;
   acc_type             energy_ff, energy_in;

   assign out_free = !valid_ff || rsp_ready;
   assign take     = frame.valid && out_free;

   assign energy     = (frame.left_sum > frame.right_sum) ? frame.left_sum : frame.right_sum;
   assign mix        = 33'(slow_ff) * 33'(125) + 33'(decay_ff) * 33'(3);
   assign slow_mix   = mix[31:7];
   assign thr_prod   = 31'(slow_mix) * 31'(34);
   assign threshold  = thr_prod[30:5];
   assign beat       = ({1'b0, energy} >= threshold) && (energy > min_energy);
   assign pair_sum   = {1'b0, energy} + {1'b0, last_beat_ff};
   assign decay_prod = 29'(decay_ff) * 29'(14);

   always_comb begin
      slow_in      = slow_ff;
      decay_in     = decay_ff;
      last_beat_in = last_beat_ff;
      since_in     = since_ff;
      beat_in      = beat_ff;
      energy_in    = energy_ff;
      valid_in     = valid_ff && !rsp_ready;
      if (take) begin
         valid_in  = 1'b1;
         beat_in   = beat;
         energy_in = energy;
         slow_in   = slow_mix;
         since_in  = (since_ff == CNT_MAX) ? since_ff : since_ff + 1'b1;
         if (beat) begin
            since_in     = '0;
            slow_in      = pair_sum[ACC_BITS:1];
            last_beat_in = energy;
         end else if (energy > decay_ff) begin
            decay_in = energy;
         end else begin
            decay_in = decay_prod[28:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff      <= '0;
         decay_ff     <= '0;
         last_beat_ff <= '0;
         since_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         slow_ff      <= slow_in;
         decay_ff     <= decay_in;
         last_beat_ff <= last_beat_in;
         since_ff     <= since_in;
         valid_ff     <= valid_in;
      end
      beat_ff   <= beat_in;
      energy_ff <= energy_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_is_beat      = beat_ff;
   assign rsp_frame_energy = energy_ff;

endmodule

// ----- design/ebd_checker.sv -----
// Port-level checks of the energy beat detector, bound to the top level.
// Depends on ebd_pkg and energy_beat_detector_core.
`timescale 1ns / 1ps

module ebd_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_is_beat,
   input  ebd_pkg::acc_type rsp_frame_energy,
   input  logic             csr_pready
);
   import ebd_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_energy) && $stable(rsp_is_beat))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_beat |-> rsp_frame_energy != '0)
      else $error("beat reported on zero energy");

   assert property (@(posedge clock) csr_pready)
      else $error("csr pready dropped");

endmodule

bind energy_beat_detector_core ebd_checker u_ebd_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for energy_beat_detector_core: stereo frames in, beat results out.
// Depends on ebd_pkg and the core; predicts each frame result and checks it on arrival.
`timescale 1ns / 1ps

module testbench;
   import ebd_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int HOLD_CYCLES      = 96;
   localparam int PHASE_PAIRS      = 180;
   localparam int SATURATING_PAIRS = 1040;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE = CSR_ADDR_BITS'(4);
   localparam logic [CSR_DATA_BITS-1:0] FLOOR_HIGH = CSR_DATA_BITS'(18874368);
   localparam sample_type FULL_POS = 16'sh7FFF;
   localparam sample_type FULL_NEG = 16'sh8000;

   typedef struct {
      logic    is_beat;
      acc_type frame_energy;
   } beat_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_left_sample = '0;
   sample_type req_right_sample = '0;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_beat;
   acc_type    rsp_frame_energy;
   logic       csr_psel = 1'b0;
   logic       csr_penable = 1'b0;
   logic       csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic       csr_pready;

   beat_result_type expected_frames[$];
   beat_result_type oldest_frame;
   int mismatches = 0;
   int send_idle_pct = 17;
   int recv_stall_pct = 82;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int pairs_sent = 0;

   acc_type energy_floor = MIN_ENERGY_RESET;
   acc_type left_level = '0;
   acc_type right_level = '0;
   acc_type trend_peak = '0;
   acc_type falloff_peak = '0;
   acc_type last_hit_energy = '0;
   logic [CNT_BITS-1:0] frames_since_hit = '0;

   energy_beat_detector_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   function automatic acc_type add_clamped(acc_type level, sample_type s);
      longint signed_value;
      longint unsigned total;
      signed_value = s;
      total = level;
      total += (signed_value < 0) ? -signed_value : signed_value;
      return (total > ACC_MAX) ? ACC_MAX : acc_type'(total);
   endfunction

   function automatic void track_frame(sample_type left, sample_type right, logic last);
      longint unsigned energy, trend, falloff, threshold;
      logic hit;
      beat_result_type result;
      left_level = add_clamped(left_level, left);
      right_level = add_clamped(right_level, right);
      if (!last) return;
      energy = (left_level > right_level) ? left_level : right_level;
      left_level = '0;
      right_level = '0;
      trend = trend_peak;
      falloff = falloff_peak;
      trend = (trend * 125 + falloff * 3) / 128;
      trend_peak = acc_type'(trend);
      if (frames_since_hit != CNT_MAX) frames_since_hit++;
      threshold = (trend * 34) / 32;
      hit = (energy >= threshold) && (energy > energy_floor);
      if (hit) begin
         frames_since_hit = '0;
         trend_peak = acc_type'((energy + last_hit_energy) / 2);
         last_hit_energy = acc_type'(energy);
      end else if (energy > falloff) begin
         falloff_peak = acc_type'(energy);
      end else begin
         falloff_peak = acc_type'((falloff * 14) / 16);
      end
      result.is_beat = hit;
      result.frame_energy = acc_type'(energy);
      expected_frames.insert(expected_frames.size(), result);
   endfunction

   task automatic send_pair(input sample_type left, input sample_type right, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_left_sample <= left;
      req_right_sample <= right;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
      track_frame(left, right, last);
      pairs_sent++;
   endtask

   task automatic send_frame(input int length, input int left_shift, input int right_shift);
      sample_type left, right;
      for (int i = 1; i <= length; i++) begin
         left = sample_type'($urandom());
         right = sample_type'($urandom());
         send_pair(left >>> left_shift, right >>> right_shift, i == length);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (addr == CSR_MIN_ENERGY) energy_floor = data[ACC_BITS-1:0];
   endtask

   task automatic check_energy_floor();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_MIN_ENERGY;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[ACC_BITS-1:0] !== energy_floor)
         report_mismatch("min_energy readback", energy_floor, csr_prdata[ACC_BITS-1:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("unexpected frame result, energy", 0, rsp_frame_energy);
         end else begin
            oldest_frame = expected_frames.pop_front();
            if (rsp_is_beat !== oldest_frame.is_beat)
               report_mismatch("is_beat", oldest_frame.is_beat, rsp_is_beat);
            if (rsp_frame_energy !== oldest_frame.frame_energy)
               report_mismatch("frame_energy", oldest_frame.frame_energy, rsp_frame_energy);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_reset_value();
      check_energy_floor();
   endtask

   task automatic test_directed_frames();
      csr_write(CSR_MIN_ENERGY, '0);
      send_pair(FULL_POS, FULL_NEG, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(FULL_NEG, FULL_NEG, 1'b0);
      send_pair(FULL_NEG, FULL_POS, 1'b1);
      send_pair(-16'sd1, 16'sd1, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b1);
      send_pair(16'sh5555, 16'shAAAA, 1'b1);
      send_pair(16'shAAAA, 16'sh5555, 1'b1);
      send_pair(16'sd100, -16'sd20000, 1'b0);
      send_pair(-16'sd200, 16'sd3000, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd12345, -16'sd12345, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(FULL_POS, FULL_POS, 1'b1);
   endtask

   task automatic test_register_limits();
      wait_idle();
      csr_write(CSR_MIN_ENERGY, '1);
      check_energy_floor();
      send_frame(8, 0, 0);
      wait_idle();
      csr_write(CSR_SPARE, 32'h0000_1234);
      check_energy_floor();
      csr_write(CSR_MIN_ENERGY, FLOOR_HIGH);
      check_energy_floor();
   endtask

   task automatic test_saturation();
      for (int i = 1; i <= SATURATING_PAIRS; i++)
         send_pair($urandom_range(1) ? FULL_POS : FULL_NEG,
                   $urandom_range(1) ? FULL_POS : FULL_NEG, i == SATURATING_PAIRS);
   endtask

   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_requests++;
      repeat (30) send_pair(sample_type'($urandom()), sample_type'($urandom()), 1'b1);
      send_idle_pct = saved_pct;
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input acc_type floor_level);
      int target;
      wait_idle();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      csr_write(CSR_MIN_ENERGY, CSR_DATA_BITS'(floor_level));
      check_energy_floor();
      target = pairs_sent + PHASE_PAIRS;
      while (pairs_sent < target) begin
         if ($urandom_range(19) == 0)
            send_frame($urandom_range(100, 400), $urandom_range(0, 2), $urandom_range(0, 2));
         else
            send_frame($urandom_range(1, 24), $urandom_range(0, 9), $urandom_range(0, 9));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_directed_frames();
      test_register_limits();
      test_saturation();
      test_random_traffic(17, 82, ACC_BITS'($urandom_range(20000, 300000)));
      test_backpressure();
      test_random_traffic(82, 17, '0);
      test_random_traffic(0, 0, MIN_ENERGY_RESET);
      wait_idle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
